@@ hw/rtl/u2u8_pkg.sv @@
// shared types and constants for the utf-16 to utf-8 transcoder
// no dependencies; imported by the encoder, the output buffer and the top level
package u2u8_pkg;

  localparam int MAX_BYTES = 6;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  localparam logic [15:0] OBJECT_CODE_RESET = 16'hFDD0;

  // up to six bytes caused by one code unit, first byte in slot 0
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [MAX_BYTES-1:0]      lasts;
    logic [CNT_W-1:0]          len;
  } batch_t;

endpackage

@@ hw/rtl/u2u8_encode.sv @@
// combinational encoder: one registered code unit plus held surrogate -> byte batch
// depends on u2u8_pkg
module u2u8_encode (
  input  logic [15:0]     unit,
  input  logic            last,
  input  logic [15:0]     held_high,
  input  logic            held_valid,
  input  logic [15:0]     object_code,
  output u2u8_pkg::batch_t batch,
  output logic [15:0]     held_high_next,
  output logic            held_valid_next
);
  import u2u8_pkg::*;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [3:0]      lasts;
    logic [2:0]      len;
  } run_t;

  localparam logic [7:0] MARK_B0 = 8'hEF;
  localparam logic [7:0] MARK_B1 = 8'hBF;
  localparam logic [7:0] MARK_B2 = 8'hBC;

  function automatic run_t encode_point(input logic [20:0] cp, input logic obj_hit);
    run_t r;
    r = '0;
    if (obj_hit) begin
      r.bytes[0] = MARK_B0;
      r.bytes[1] = MARK_B1;
      r.bytes[2] = MARK_B2;
      r.lasts    = 4'b0100;
      r.len      = 3'd3;
    end else if (cp <= 21'h7F) begin
      r.bytes[0] = cp[7:0];
      r.lasts    = 4'b0001;
      r.len      = 3'd1;
    end else if (cp <= 21'h7FF) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.lasts    = 4'b0010;
      r.len      = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.lasts    = 4'b0100;
      r.len      = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.lasts    = 4'b1000;
      r.len      = 3'd4;
    end
    return r;
  endfunction

  logic        is_high;
  logic        is_low;
  logic        paired;
  logic        hold;
  logic [20:0] pair_cp;
  run_t        flush_run;
  run_t        main_run;

  assign is_high = unit inside {[16'hD800:16'hDBFF]};
  assign is_low  = unit inside {[16'hDC00:16'hDFFF]};
  assign paired  = held_valid && is_low;
  assign hold    = is_high && !last && !paired;

  // supplementary point: 0x10000 + ten bits from each half
  assign pair_cp = 21'h10000 + {1'b0, held_high[9:0], unit[9:0]};

  assign flush_run = encode_point({5'd0, held_high}, held_high == object_code);

  always_comb begin
    if (paired) begin
      main_run = encode_point(pair_cp, 1'b0);
    end else if (hold) begin
      main_run = '0;
    end else begin
      main_run = encode_point({5'd0, unit}, unit == object_code);
    end
  end

  // a flushed surrogate is always three bytes, so the new unit starts at slot 3
  always_comb begin
    batch = '0;
    if (held_valid && !paired) begin
      batch.bytes[2:0] = flush_run.bytes[2:0];
      batch.lasts[2:0] = flush_run.lasts[2:0];
      batch.bytes[5:3] = main_run.bytes[2:0];
      batch.lasts[5:3] = main_run.lasts[2:0];
      batch.len        = CNT_W'(3) + CNT_W'(main_run.len);
    end else begin
      batch.bytes[3:0] = main_run.bytes;
      batch.lasts[3:0] = main_run.lasts;
      batch.len        = CNT_W'(main_run.len);
    end
  end

  assign held_valid_next = hold;
  assign held_high_next  = hold ? unit : 16'd0;

endmodule

@@ hw/rtl/u2u8_out_buf.sv @@
// result buffer: holds one batch and shifts its bytes out one word at a time
// depends on u2u8_pkg
module u2u8_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  u2u8_pkg::batch_t batch,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             run_last
);
  import u2u8_pkg::*;

  logic [MAX_BYTES-1:0][7:0] bytes;
  logic [MAX_BYTES-1:0]      lasts;
  logic [CNT_W-1:0]          rem;
  logic                      take;

  assign out_valid = rem != '0;
  assign take      = out_valid && out_ready;
  // free when empty or when the last pending word leaves this cycle
  assign free      = (rem == '0) || (rem == CNT_W'(1) && out_ready);
  assign out_byte  = bytes[0];
  assign run_last  = lasts[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load && free) begin
      rem <= batch.len;
    end else if (take) begin
      rem <= rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      bytes <= batch.bytes;
      lasts <= batch.lasts;
    end else if (take) begin
      bytes <= {8'd0, bytes[MAX_BYTES-1:1]};
      lasts <= {1'b0, lasts[MAX_BYTES-1:1]};
    end
  end

endmodule

@@ hw/rtl/utf16_to_utf8_with_object_marker.sv @@
// utf-16 to utf-8 transcoder: top level with input register, surrogate hold and config
// depends on u2u8_pkg, u2u8_encode, u2u8_out_buf
//
// Usage:
//   Input words (code_unit, end_of_text) arrive on in_valid/in_ready; output words
//   (out_byte, run_last) leave on out_valid/out_ready, one utf-8 byte per word.
//   run_last marks the final byte of each encoded character.
//   A high surrogate (not end_of_text) is held until the next unit; a following low
//   surrogate makes a four-byte sequence, anything else flushes the held one as three bytes first.
//   A unit equal to object_code (and an unpaired surrogate equal to it) gives EF BF BC.
//   object_code (cfg_we/cfg_wdata): user writes it only with no word in flight, unchecked.
// Timing:
//   An accepted unit is registered in the input register; once the result buffer is
//   free its 0 to 6 bytes are loaded there, and the first byte is offered from it.
//   The result buffer sends one byte per cycle while out_ready is high; the next unit
//   is loaded in the cycle the last byte of the previous one is taken.
// Reset and stall:
//   rst clears the input register, the held surrogate and the buffer, and restores
//   object_code to FDD0. While out_ready is low the buffer holds its byte, the input
//   register fills, and in_ready drops.
module utf16_to_utf8_with_object_marker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import u2u8_pkg::*;

  logic        s1_valid;
  logic [15:0] s1_unit;
  logic        s1_last;
  logic [15:0] held_high;
  logic        held_valid;
  logic [15:0] held_high_next;
  logic        held_valid_next;
  logic [15:0] object_code;
  logic        buf_free;
  logic        advance;
  batch_t      batch;

  assign advance  = s1_valid && buf_free;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_unit <= code_unit;
      s1_last <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_high  <= 16'd0;
    end else if (advance) begin
      held_valid <= held_valid_next;
      held_high  <= held_high_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      object_code <= OBJECT_CODE_RESET;
    end else if (cfg_we) begin
      object_code <= cfg_wdata;
    end
  end

  u2u8_encode u_encode (
    .unit            (s1_unit),
    .last            (s1_last),
    .held_high       (held_high),
    .held_valid      (held_valid),
    .object_code     (object_code),
    .batch           (batch),
    .held_high_next  (held_high_next),
    .held_valid_next (held_valid_next)
  );

  u2u8_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .batch     (batch),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

endmodule

@@ hw/rtl/u2u8_checker.sv @@
// port-level checks for the utf-16 to utf-8 transcoder, bound to the top level
// depends on utf16_to_utf8_with_object_marker
module u2u8_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        run_last
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // the last byte of a run is never a lead byte
  a_last_not_lead: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_last |-> out_byte[7:6] != 2'b11)
    else $error("run ends on a lead byte");

  // a lead byte is followed at once by a continuation byte
  a_lead_then_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_byte[7:6] == 2'b11 |=> out_valid && out_byte[7:6] == 2'b10)
    else $error("lead byte not followed by continuation");

endmodule

bind utf16_to_utf8_with_object_marker u2u8_checker u_checker (.*);
